### hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/nbl_pkg.sv
`default_nettype none
package nbl_pkg;

  localparam int WORDW = 18;
  localparam int IDXW  = 12;
  localparam int VALW  = 32;

  localparam logic [1:0] CMD_NODE  = 2'd0;
  localparam logic [1:0] CMD_LEAF  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic CFG_VALUE_MODE  = 1'b0;
  localparam logic CFG_MODEL_ORDER = 1'b1;

  localparam logic [VALW-1:0] ONE_Q24 = 32'h0100_0000;
  localparam logic [VALW-1:0] SAT32   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [WORDW-1:0] word;
    logic [IDXW-1:0]  child;
    logic [VALW-1:0]  backoff;
    logic [VALW-1:0]  prob;
  } node_entry_t;

  typedef struct packed {
    logic [WORDW-1:0] word;
    logic [VALW-1:0]  prob;
  } leaf_entry_t;

endpackage
`default_nettype wire

### hdl/nbl_ram.sv
`default_nettype none
module nbl_ram #(
  parameter int WIDTH = 94,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/nbl_combine.sv
`default_nettype none
module nbl_combine
  import nbl_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            log_mode,
  input  wire logic [VALW-1:0] bow,
  input  wire logic [VALW-1:0] value,
  output logic                 done,
  output logic      [VALW-1:0] result
);

  logic [2*VALW-1:0] prod;
  logic              pend;
  logic              mode_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= pend;
      pend <= start;
      if (start) begin
        mode_q <= log_mode;
        if (log_mode) begin
          prod <= (2*VALW)'(bow) + (2*VALW)'(value);
        end else begin
          prod <= bow * value;
        end
      end
      if (pend) begin
        if (mode_q) begin
          result <= (prod[VALW]) ? SAT32 : prod[VALW-1:0];
        end else begin
          // q8.24 product, truncated
          result <= (|prod[2*VALW-1:VALW+24]) ? SAT32 : prod[VALW+23:24];
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/ngram_backoff_lookup_top.sv
`default_nettype none
// Back-off n-gram lookup over a level-ordered trie held in two synchronous memories: a node
// memory (MAX_ORDER levels of word, first child, backoff and value) and a leaf memory (word
// and value). A write beat (command 0 or 1) stores one entry and yields
// no response. A query beat walks the trie from the root, one lower-bound binary search per
// level, and backs off by dropping the oldest word when the full n-gram is missing, adding
// (log mode) or Q8.24-multiplying (direct mode) the context backoff, innermost first; log
// sums saturate, direct products truncate and saturate. Each try walks its levels in order,
// one search per level, where a search over a span of s entries takes at most
// floor(log2(s))+1 steps, and a try that misses stops at the level where it misses; one
// backoff is applied per failed try. Every binary-search step issues a memory read in
// S_SISSUE and compares the registered read data in S_SCMP. Only one query is in
// flight; the request side stalls until the response is loaded into the output register,
// and a new beat is taken while that response waits to be drained.
module ngram_backoff_lookup_top
  import nbl_pkg::*;
#(
  parameter int MAX_ORDER     = 3,
  parameter int LEVEL_ENTRIES = 4096,
  parameter int WORD_BITS     = 18
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // request channel
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire logic [1:0]       command,
  input  wire logic [1:0]       table_level,
  input  wire logic [IDXW-1:0]  entry_index,
  input  wire logic [WORDW-1:0] entry_word,
  input  wire logic [IDXW-1:0]  entry_child,
  input  wire logic [VALW-1:0]  entry_backoff,
  input  wire logic [VALW-1:0]  entry_prob,
  input  wire logic [1:0]       query_length,
  input  wire logic [WORDW-1:0] query_word0,
  input  wire logic [WORDW-1:0] query_word1,
  input  wire logic [WORDW-1:0] query_word2,
  // response channel
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output logic      [VALW-1:0]  score,
  output logic      [1:0]       matched_length,
  // configuration
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [1:0]       cfg_data
);

  `include "assert_macros.svh"

  localparam int AW  = $clog2(LEVEL_ENTRIES);
  localparam int NAW = $clog2(MAX_ORDER * LEVEL_ENTRIES);
  // search positions must hold the level size itself and any child pointer
  localparam int PW  = ((AW > IDXW) ? AW : IDXW) + 1;
  localparam logic [WORDW-1:0] WMASK = (WORD_BITS >= WORDW) ? {WORDW{1'b1}} :
                                       WORDW'((64'd1 << WORD_BITS) - 64'd1);
  localparam logic [PW-1:0] LE_P = PW'(LEVEL_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_TRY, S_CTX0, S_CTX1, S_CTX2, S_SISSUE, S_SCMP, S_PROBE, S_PCHK,
    S_SCORE, S_SCORE2, S_APPLY, S_WAIT, S_DONE
  } state_t;

  function automatic logic [NAW-1:0] node_addr(input logic [2:0] level,
                                               input logic [AW-1:0] idx);
    logic [NAW-1:0] a;
    a = '0;
    if (level < 3'(MAX_ORDER)) begin
      a = NAW'(level) * NAW'(LEVEL_ENTRIES) + NAW'(idx);
    end
    return a;
  endfunction

  state_t           state;
  logic             value_mode;
  logic [1:0]       model_order;

  // query context
  logic [WORDW-1:0] words [3];
  logic [1:0]       qlen;
  logic [1:0]       n;         // length of the n-gram being tried
  logic [1:0]       off;       // words dropped from the front
  logic [1:0]       lvl;       // node level being walked
  logic [AW-1:0]    cur;
  logic [VALW-1:0]  bow;
  logic [VALW-1:0]  bows [3];
  logic [1:0]       nb;
  logic [PW-1:0]    h, lo, hi, tcl, mid;
  logic             is_leaf;
  logic [VALW-1:0]  acc_score;

  // memory ports
  node_entry_t      node_rd, node_wd;
  leaf_entry_t      leaf_rd, leaf_wd;
  logic [NAW-1:0]   node_ra, node_wa;
  logic [AW-1:0]    leaf_ra, leaf_wa;
  logic             node_we, leaf_we;

  // combine unit
  logic             cmb_start, cmb_done;
  logic [VALW-1:0]  cmb_result;

  logic             req_accept;
  logic [1:0]       nlev;
  logic [1:0]       n0;
  logic             idx_ok;
  logic [WORDW-1:0] qword, rword;
  logic [PW-1:0]    t_ext, hi_c, mid_c, lo_n, hi_n;
  logic             hit, try_fail, use_leaf;
  logic [2:0]       lvl_up;
  logic [AW-1:0]    cur_nxt;
  logic [1:0]       widx;

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign nlev       = (32'(model_order) > MAX_ORDER) ? 2'(MAX_ORDER) : model_order;
  assign n0         = (query_length > nlev) ? nlev : query_length;
  assign idx_ok     = PW'(entry_index) < LE_P;
  assign lvl_up     = 3'(lvl) + 3'd1;
  assign cur_nxt    = (cur == AW'(LEVEL_ENTRIES - 1)) ? '0 : cur + AW'(1);
  assign widx       = off + lvl;
  assign use_leaf   = (n == nlev) && (n != 2'd0);
  assign cmb_start  = (state == S_APPLY);

  // entry writes happen only while idle, so they never meet a query read
  assign node_we = req_accept && (command == CMD_NODE) &&
                   (32'(table_level) < MAX_ORDER) && idx_ok;
  assign leaf_we = req_accept && (command == CMD_LEAF) && idx_ok;
  assign node_wa = node_addr({1'b0, table_level}, AW'(entry_index));
  assign leaf_wa = AW'(entry_index);
  assign node_wd = '{word: entry_word, child: entry_child, backoff: entry_backoff,
                     prob: entry_prob};
  assign leaf_wd = '{word: entry_word, prob: entry_prob};

  always_comb begin
    qword = words[widx] & WMASK;
    rword = (is_leaf ? leaf_rd.word : node_rd.word) & WMASK;
    hit   = (rword == qword);
    t_ext = PW'(node_rd.child);
    hi_c  = (t_ext > LE_P) ? LE_P : t_ext;
    mid_c = lo + ((hi - lo) >> 1);
    if (rword < qword) begin
      lo_n = mid + PW'(1);
      hi_n = hi;
    end else begin
      lo_n = lo;
      hi_n = mid;
    end
    try_fail = ((state == S_CTX2) && (h >= hi_c)) ||
               ((state == S_SCMP) && !(lo_n < hi_n) && (lo_n >= tcl)) ||
               ((state == S_PCHK) && !hit);
  end

  // read addresses: data comes back in the following state
  always_comb begin
    node_ra = node_addr({1'b0, lvl}, cur);
    leaf_ra = cur;
    unique case (state)
      S_CTX1:   node_ra = node_addr({1'b0, lvl}, cur_nxt);
      S_SISSUE: begin
        node_ra = node_addr(lvl_up, AW'(mid_c));
        leaf_ra = AW'(mid_c);
      end
      S_PROBE: begin
        node_ra = node_addr(lvl_up, AW'(lo));
        leaf_ra = AW'(lo);
      end
      S_SCORE:  node_ra = node_addr({1'b0, n}, cur);
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      value_mode  <= 1'b0;
      model_order <= 2'd3;
      nb          <= 2'd0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_VALUE_MODE:  value_mode  <= cfg_data[0];
          CFG_MODEL_ORDER: model_order <= cfg_data;
          default:         ;
        endcase
      end
      // in S_DONE the output register is reloaded below
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      priority if (try_fail) begin
        // drop the oldest word and keep the backoff for later
        bows[nb] <= bow;
        nb       <= nb + 2'd1;
        off      <= off + 2'd1;
        n        <= n - 2'd1;
        state    <= S_TRY;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (req_accept && (command == CMD_QUERY)) begin
              words[0] <= query_word0;
              words[1] <= query_word1;
              words[2] <= query_word2;
              qlen     <= query_length;
              n        <= n0;
              off      <= query_length - n0;
              nb       <= 2'd0;
              state    <= S_TRY;
            end
          end
          S_TRY: begin
            lvl   <= 2'd0;
            cur   <= '0;
            bow   <= value_mode ? ONE_Q24 : '0;
            state <= (n == 2'd0) ? S_SCORE : S_CTX0;
          end
          S_CTX0: state <= S_CTX1;
          S_CTX1: begin
            h <= PW'(node_rd.child);
            if (lvl == n - 2'd1) begin
              bow <= node_rd.backoff;
            end
            state <= S_CTX2;
          end
          S_CTX2: begin
            lo      <= h;
            hi      <= hi_c;
            tcl     <= hi_c;
            is_leaf <= (lvl_up == {1'b0, nlev});
            state   <= S_SISSUE;
          end
          S_SISSUE: begin
            mid   <= mid_c;
            state <= S_SCMP;
          end
          S_SCMP: begin
            lo    <= lo_n;
            hi    <= hi_n;
            state <= (lo_n < hi_n) ? S_SISSUE : S_PROBE;
          end
          S_PROBE: state <= S_PCHK;
          S_PCHK: begin
            cur <= AW'(lo);
            if (lvl == n - 2'd1) begin
              state <= S_SCORE;
            end else begin
              lvl   <= lvl + 2'd1;
              state <= S_CTX0;
            end
          end
          S_SCORE: state <= S_SCORE2;
          S_SCORE2: begin
            acc_score <= use_leaf ? leaf_rd.prob : node_rd.prob;
            state     <= (nb != 2'd0) ? S_APPLY : S_DONE;
          end
          S_APPLY: state <= S_WAIT;
          S_WAIT: begin
            if (cmb_done) begin
              acc_score <= cmb_result;
              nb        <= nb - 2'd1;
              state     <= (nb == 2'd1) ? S_DONE : S_APPLY;
            end
          end
          S_DONE: begin
            if (!rsp_valid || !rsp_stall) begin
              rsp_valid      <= 1'b1;
              score          <= acc_score;
              matched_length <= n;
              state          <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  nbl_ram #(
    .WIDTH ($bits(node_entry_t)),
    .DEPTH (MAX_ORDER * LEVEL_ENTRIES),
    .AW    (NAW)
  ) u_node_mem (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_wa),
    .wdata (node_wd),
    .raddr (node_ra),
    .rdata (node_rd)
  );

  nbl_ram #(
    .WIDTH ($bits(leaf_entry_t)),
    .DEPTH (LEVEL_ENTRIES),
    .AW    (AW)
  ) u_leaf_mem (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_wa),
    .wdata (leaf_wd),
    .raddr (leaf_ra),
    .rdata (leaf_rd)
  );

  // backoffs apply innermost first, so the last one kept goes first
  nbl_combine u_combine (
    .clk      (clk),
    .rst      (rst),
    .start    (cmb_start),
    .log_mode (!value_mode),
    .bow      (bows[nb - 2'd1]),
    .value    (acc_score),
    .done     (cmb_done),
    .result   (cmb_result)
  );

  `ASSERT_IMPLIES(a_search_open, clk, rst, state == S_SCMP, lo < hi, "empty search window")
  `ASSERT_IMPLIES(a_apply_pending, clk, rst, state == S_APPLY, nb != 2'd0, "no backoff to apply")
  `ASSERT_IMPLIES(a_match_len, clk, rst, state == S_DONE, n <= qlen, "match longer than query")
  `ASSERT_NEXT(a_query_start, clk, rst, req_accept && (command == CMD_QUERY), state == S_TRY, "query not started")

endmodule
`default_nettype wire
